FILE: rtl/imad_pkg.sv
package imad_pkg;

  localparam logic [6:0] MAX_INDEX = 7'd88;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_DATA   = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [15:0] predictor;
    logic [6:0]         step_index;
  } dec_state_t;

  typedef struct packed {
    op_e                op;
    logic [7:0]         code_byte;
    logic signed [15:0] start_sample;
    logic [6:0]         start_index;
    logic               end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_of_item;
    logic               block_done;
  } out_item_t;

  // Quantizer step size for each step index; indexes past the end read the top step.
  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    unique case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
      7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
      7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
      7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
      7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
      7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
      7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
      7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
      7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
      7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
      7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Step index adjustment from the magnitude bits of a code.
  function automatic logic signed [4:0] index_move(input logic [2:0] mag);
    logic signed [4:0] m;
    unique case (mag)
      3'd4:    m = 5'sd2;
      3'd5:    m = 5'sd4;
      3'd6:    m = 5'sd6;
      3'd7:    m = 5'sd8;
      default: m = -5'sd1;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/imad_decode.sv
module imad_decode (
  input  imad_pkg::dec_state_t state_i,
  input  imad_pkg::in_item_t   item_i,
  input  logic                 phase_i,
  output imad_pkg::dec_state_t state_o,
  output imad_pkg::out_item_t  result_o,
  output logic                 consume_o
);

  logic [3:0]         code;
  logic [14:0]        step;
  logic [16:0]        diff;
  logic signed [17:0] pred_ext;
  logic signed [17:0] diff_ext;
  logic signed [17:0] acc;
  logic signed [15:0] pred_new;
  logic signed [4:0]  idx_move;
  logic signed [7:0]  idx_sum;
  logic [6:0]         idx_new;

  // Pick the low nibble first, the high one on the second pass.
  assign code = phase_i ? item_i.code_byte[7:4] : item_i.code_byte[3:0];
  assign step = imad_pkg::step_size(state_i.step_index);

  assign diff = 17'(step >> 3)
              + (code[0] ? 17'(step >> 2) : 17'd0)
              + (code[1] ? 17'(step >> 1) : 17'd0)
              + (code[2] ? 17'(step)      : 17'd0);

  assign pred_ext = {{2{state_i.predictor[15]}}, state_i.predictor};
  assign diff_ext = {1'b0, diff};
  assign acc      = code[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);

  // Clip one-sided: rising toward +32767, falling toward -32767.
  always_comb begin
    if (!code[3] && (acc > 18'sd32767)) begin
      pred_new = 16'sh7FFF;
    end else if (code[3] && (acc < -18'sd32767)) begin
      pred_new = 16'sh8001;
    end else begin
      pred_new = acc[15:0];
    end
  end

  assign idx_move = imad_pkg::index_move(code[2:0]);
  assign idx_sum  = $signed({1'b0, state_i.step_index})
                  + $signed({{3{idx_move[4]}}, idx_move});

  always_comb begin
    if (idx_sum < 8'sd0) begin
      idx_new = 7'd0;
    end else if (idx_sum > $signed({1'b0, imad_pkg::MAX_INDEX})) begin
      idx_new = imad_pkg::MAX_INDEX;
    end else begin
      idx_new = idx_sum[6:0];
    end
  end

  always_comb begin
    unique case (item_i.op)
      imad_pkg::OP_HEADER: begin
        state_o.predictor  = item_i.start_sample;
        state_o.step_index = (item_i.start_index > imad_pkg::MAX_INDEX) ?
                             imad_pkg::MAX_INDEX : item_i.start_index;
        result_o.sample       = item_i.start_sample;
        result_o.last_of_item = 1'b1;
        result_o.block_done   = item_i.end_of_block;
        consume_o             = 1'b1;
      end
      default: begin
        state_o.predictor     = pred_new;
        state_o.step_index    = idx_new;
        result_o.sample       = pred_new;
        result_o.last_of_item = phase_i;
        result_o.block_done   = phase_i & item_i.end_of_block;
        consume_o             = phase_i;
      end
    endcase
  end

endmodule

FILE: rtl/ima_adpcm_nibble_decoder.sv
// IMA ADPCM 4-bit decoder. A header item (op 0) loads predictor and step index
// (index saturated to 88) and yields one sample, the start sample itself. A data
// item (op 1) yields two samples, low nibble first; the second carries
// last_of_item and, with end_of_block set, block_done. Throughput is one sample
// per cycle while the output side does not stall, set by the single nibble decoder
// that sits between the input register and the output register. The first sample
// of an item is registered in the input register and then in the output register.
module ima_adpcm_nibble_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [7:0]         code_byte_i,
  input  logic signed [15:0] start_sample_i,
  input  logic [6:0]         start_index_i,
  input  logic               end_of_block_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o,
  output logic               last_of_item_o,
  output logic               block_done_o
);

  imad_pkg::in_item_t   in_item_q;
  logic                 in_valid_q;
  logic                 phase_q;
  imad_pkg::dec_state_t state_q;
  imad_pkg::dec_state_t state_d;
  imad_pkg::out_item_t  out_item_q;
  imad_pkg::out_item_t  out_item_d;
  logic                 out_valid_q;

  logic out_load;
  logic fire;
  logic consume;
  logic done_item;
  logic accept;

  imad_decode u_decode (
    .state_i   (state_q),
    .item_i    (in_item_q),
    .phase_i   (phase_q),
    .state_o   (state_d),
    .result_o  (out_item_d),
    .consume_o (consume)
  );

  // The output register takes a new sample when empty or being drained.
  assign out_load  = !out_valid_q || !out_stall_i;
  // Decode one nibble (or the header) each cycle the output can take it.
  assign fire      = in_valid_q && out_load;
  assign done_item = fire && consume;
  // Take the next item as soon as the held one produces its final sample.
  assign in_stall_o = in_valid_q && !done_item;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (done_item) begin
        in_valid_q <= 1'b0;
      end
      // Advance to the high nibble after the low one; restart on a new item.
      if (done_item) begin
        phase_q <= 1'b0;
      end else if (fire) begin
        phase_q <= 1'b1;
      end
    end
  end

  // Hold the accepted item's payload for the whole of its decode.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q.op           <= imad_pkg::op_e'(op_i);
      in_item_q.code_byte    <= code_byte_i;
      in_item_q.start_sample <= start_sample_i;
      in_item_q.start_index  <= start_index_i;
      in_item_q.end_of_block <= end_of_block_i;
    end
  end

  // Predictor and step index advance with every sample handed to the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.predictor  <= 16'sd0;
      state_q.step_index <= 7'd0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = out_item_q.sample;
  assign last_of_item_o = out_item_q.last_of_item;
  assign block_done_o   = out_item_q.block_done;

endmodule

FILE: rtl/imad_checker.sv
module imad_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               op_i,
  input logic [7:0]         code_byte_i,
  input logic signed [15:0] start_sample_i,
  input logic [6:0]         start_index_i,
  input logic               end_of_block_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] sample_o,
  input logic               last_of_item_o,
  input logic               block_done_o
);

  // Hold a stalled result item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled result item changed");

  // Block end only ever comes with the final sample of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_item_o |-> !block_done_o)
    else $error("block_done without last_of_item");

  // The second sample of a data item follows its first without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_item_o |=> out_valid_o)
    else $error("gap between the two samples of a data item");

  // Hold a stalled input item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i &&
      $stable({op_i, code_byte_i, start_sample_i, start_index_i, end_of_block_i}))
    else $error("stalled input item changed");

endmodule

bind ima_adpcm_nibble_decoder imad_checker u_imad_checker (.*);
